### design/plcb_pkg.sv
// Shared types and constants for the persistence layer capture buffer.
// Holds the request and result payloads, the queued operation and the command codes.
// No dependencies.
package plcb_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEF_LAYER_COUNT = 8;
	localparam int DEF_LAYER_DEPTH = 1024;
	localparam int DEF_QUEUE_DEPTH = 2;

	// Field widths of the request and result payloads.
	localparam int CMD_W   = 2;
	localparam int RAW_W   = 16;
	localparam int SEL_W   = 3;
	localparam int IDX_W   = 10;
	localparam int VAL_W   = 16;
	localparam int COLOR_W = 16;
	localparam int LEN_W   = 11;
	localparam int GAIN_W  = 16;

	// Sample scaling: 12-bit signed code times an unsigned Q4.12 gain.
	localparam int CODE_W     = 12;
	localparam int GAIN_FRAC  = 12;
	localparam int PROD_W     = CODE_W + GAIN_W + 1;
	localparam int ROUND_HALF = 1 << (GAIN_FRAC - 1);

	// RGB565 component widths.
	localparam int COMP_B_W = 5;
	localparam int COMP_G_W = 6;
	localparam int COMP_R_W = 5;

	// Configuration port.
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;
	localparam int REG_ADDR_LSB = 2;

	localparam logic [COLOR_W-1:0] BASE_COLOR_RST  = 16'hFFFF;
	localparam logic [GAIN_W-1:0]  SAMPLE_GAIN_RST = 16'd4096;

	typedef enum logic {
		REG_BASE_COLOR  = 1'b0,
		REG_SAMPLE_GAIN = 1'b1
	} reg_idx_t;

	// Command codes carried in a request.
	typedef enum logic [CMD_W-1:0] {
		CMD_STORE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// Operation kind after classification in the front end.
	typedef enum logic [1:0] {
		OP_STORE,
		OP_READ,
		OP_CLEAR,
		OP_NONE
	} op_kind_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [RAW_W-1:0] sample_raw;
		logic             batch_start;
		logic [SEL_W-1:0] layer_sel;
		logic [IDX_W-1:0] entry_index;
	} item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    read_valid;
		logic [COLOR_W-1:0]      layer_color;
		logic [LEN_W-1:0]        fill_length;
		logic [LEN_W-1:0]        to_transmit;
	} result_t;

	// One classified request as it waits between front and back end.
	typedef struct packed {
		op_kind_t                kind;
		logic                    batch;
		logic signed [VAL_W-1:0] sample;
		logic [SEL_W-1:0]        sel;
		logic                    sel_ok;
		logic [IDX_W-1:0]        idx;
		logic [COLOR_W-1:0]      color;
	} op_t;

endpackage

### design/plcb_if.sv
// Valid/ready channel interfaces for requests and results of the capture buffer.
// Depends on plcb_pkg for the payload types.
interface plcb_item_if;
	logic            valid;
	logic            ready;
	plcb_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface plcb_result_if;
	logic              valid;
	logic              ready;
	plcb_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/plcb_front.sv
// Front end: accepts requests, classifies the command, scales the sample and dims the color.
// Depends on plcb_pkg and plcb_if.
module plcb_front #(
	parameter int LAYER_COUNT = plcb_pkg::DEF_LAYER_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	plcb_item_if.sink                     item,
	input  logic [plcb_pkg::COLOR_W-1:0]  base_color,
	input  logic [plcb_pkg::GAIN_W-1:0]   sample_gain,
	output logic                          op_valid,
	input  logic                          op_ready,
	output plcb_pkg::op_t                 op
);

	// Weight width and the reciprocal used to divide by the layer count.
	localparam int WW  = $clog2(LAYER_COUNT + 1);
	localparam int NB  = plcb_pkg::COMP_G_W + WW;
	localparam int DS  = NB + $clog2(LAYER_COUNT);
	localparam int DM  = ((1 << DS) + LAYER_COUNT - 1) / LAYER_COUNT;
	localparam int DPW = 2 * NB + 2;
	localparam int QW  = plcb_pkg::PROD_W + 1 - plcb_pkg::GAIN_FRAC;

	logic                                  valid_s1;
	plcb_pkg::op_kind_t                    kind_s1;
	logic                                  batch_s1;
	logic [plcb_pkg::SEL_W-1:0]            sel_s1;
	logic                                  sel_ok_s1;
	logic [plcb_pkg::IDX_W-1:0]            idx_s1;
	logic signed [plcb_pkg::PROD_W-1:0]    prod_s1;
	logic [NB-1:0]                         pr_s1;
	logic [NB-1:0]                         pg_s1;
	logic [NB-1:0]                         pb_s1;

	logic                                  take;
	plcb_pkg::op_kind_t                    kind_d;
	logic signed [plcb_pkg::CODE_W-1:0]    code;
	logic signed [plcb_pkg::GAIN_W:0]      gain;
	logic [WW-1:0]                         weight;
	logic [plcb_pkg::COMP_R_W-1:0]         comp_r;
	logic [plcb_pkg::COMP_G_W-1:0]         comp_g;
	logic [plcb_pkg::COMP_B_W-1:0]         comp_b;

	logic signed [plcb_pkg::PROD_W:0]      rnd;
	logic [QW-1:0]                         quo;
	logic [QW-plcb_pkg::VAL_W:0]           quo_hi;
	logic signed [plcb_pkg::VAL_W-1:0]     sample_sat;
	logic [DPW-1:0]                        qr;
	logic [DPW-1:0]                        qg;
	logic [DPW-1:0]                        qb;

	// A new request enters whenever the stage is empty or drains this cycle.
	assign item.ready = !valid_s1 || op_ready;
	assign take       = item.valid && item.ready;

	// Classify the command and prepare the multiplier operands.
	always_comb begin
		case (item.data.cmd)
			plcb_pkg::CMD_STORE: kind_d = plcb_pkg::OP_STORE;
			plcb_pkg::CMD_READ:  kind_d = plcb_pkg::OP_READ;
			plcb_pkg::CMD_CLEAR: kind_d = plcb_pkg::OP_CLEAR;
			default:             kind_d = plcb_pkg::OP_NONE;
		endcase
		code   = signed'(item.data.sample_raw[plcb_pkg::CODE_W-1:0]);
		gain   = signed'({1'b0, sample_gain});
		weight = WW'(LAYER_COUNT) - WW'(item.data.layer_sel);
		comp_b = base_color[plcb_pkg::COMP_B_W-1:0];
		comp_g = base_color[plcb_pkg::COMP_B_W +: plcb_pkg::COMP_G_W];
		comp_r = base_color[plcb_pkg::COLOR_W-1 -: plcb_pkg::COMP_R_W];
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload: decoded fields and the gain and weight products.
	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1   <= kind_d;
			batch_s1  <= item.data.batch_start;
			sel_s1    <= item.data.layer_sel;
			sel_ok_s1 <= int'(item.data.layer_sel) < LAYER_COUNT;
			idx_s1    <= item.data.entry_index;
			prod_s1   <= plcb_pkg::PROD_W'(code) * plcb_pkg::PROD_W'(gain);
			pr_s1     <= NB'(comp_r) * NB'(weight);
			pg_s1     <= NB'(comp_g) * NB'(weight);
			pb_s1     <= NB'(comp_b) * NB'(weight);
		end
	end

	// Round half up, drop the fraction and saturate to 16 bits.
	always_comb begin
		rnd    = (plcb_pkg::PROD_W + 1)'(prod_s1) + (plcb_pkg::PROD_W + 1)'(plcb_pkg::ROUND_HALF);
		quo    = rnd[plcb_pkg::PROD_W -: QW];
		quo_hi = quo[QW-1:plcb_pkg::VAL_W-1];
		if (quo_hi == '0 || quo_hi == '1) begin
			sample_sat = signed'(quo[plcb_pkg::VAL_W-1:0]);
		end else if (quo[QW-1]) begin
			sample_sat = signed'({1'b1, {(plcb_pkg::VAL_W-1){1'b0}}});
		end else begin
			sample_sat = signed'({1'b0, {(plcb_pkg::VAL_W-1){1'b1}}});
		end
	end

	// Divide each weighted component by the layer count with a reciprocal multiply.
	always_comb begin
		qr = DPW'(pr_s1) * DPW'(DM);
		qg = DPW'(pg_s1) * DPW'(DM);
		qb = DPW'(pb_s1) * DPW'(DM);
	end

	// Assemble the classified operation for the queue.
	always_comb begin
		op.kind   = kind_s1;
		op.batch  = batch_s1;
		op.sample = sample_sat;
		op.sel    = sel_s1;
		op.sel_ok = sel_ok_s1;
		op.idx    = idx_s1;
		if (sel_ok_s1) begin
			op.color = {qr[DS +: plcb_pkg::COMP_R_W], qg[DS +: plcb_pkg::COMP_G_W],
				qb[DS +: plcb_pkg::COMP_B_W]};
		end else begin
			op.color = '0;
		end
	end

	assign op_valid = valid_s1;

endmodule

### design/plcb_queue.sv
// Short operation queue between the front end and the back end.
// Depends on plcb_pkg for the operation type.
module plcb_queue #(
	parameter int DEPTH = plcb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  plcb_pkg::op_t push_op,
	output logic          pop_valid,
	input  logic          pop,
	output plcb_pkg::op_t pop_op
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	plcb_pkg::op_t      entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop_op     = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

### design/plcb_back.sv
// Back end: carries out store, read and clear on the layer store and drives the result register.
// Depends on plcb_pkg and plcb_if.
module plcb_back #(
	parameter int LAYER_COUNT = plcb_pkg::DEF_LAYER_COUNT,
	parameter int LAYER_DEPTH = plcb_pkg::DEF_LAYER_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  plcb_pkg::op_t op,
	output logic          op_pop,
	plcb_result_if.source result
);

	localparam int SW = $clog2(LAYER_COUNT);
	localparam int PW = $clog2(LAYER_DEPTH);
	localparam int LW = $clog2(LAYER_DEPTH + 1);
	localparam int IW = (LW > plcb_pkg::IDX_W) ? LW : plcb_pkg::IDX_W;
	localparam int AW = ((SW > plcb_pkg::SEL_W) ? SW : plcb_pkg::SEL_W) + 1;
	localparam logic [LW-1:0] DEPTH_L   = LW'(LAYER_DEPTH);
	localparam logic [SW-1:0] LAST_SLOT = SW'(LAYER_COUNT - 1);

	logic signed [plcb_pkg::VAL_W-1:0] mem [LAYER_COUNT][LAYER_DEPTH];

	logic [SW-1:0]                     newest_q;
	logic [LW-1:0]                     newest_len_q;
	logic [LW-1:0]                     len_q [LAYER_COUNT];
	logic                              out_valid_q;
	logic                              read_valid_q;
	logic [plcb_pkg::COLOR_W-1:0]      color_q;
	logic [plcb_pkg::LEN_W-1:0]        fill_q;
	logic [plcb_pkg::LEN_W-1:0]        xmit_q;
	logic signed [plcb_pkg::VAL_W-1:0] rd_q;

	logic                              full;
	logic                              rotate;
	logic [SW-1:0]                     slot_n;
	logic [LW-1:0]                     len_base;
	logic                              do_write;
	logic [LW-1:0]                     len_store;
	logic [AW-1:0]                     slot_sum;
	logic [AW-1:0]                     slot_wrap;
	logic [SW-1:0]                     rd_slot;
	logic                              hit;
	logic [LW-1:0]                     len_after;
	logic [LW-1:0]                     xmit;
	logic [PW-1:0]                     wr_pos;
	logic [PW-1:0]                     rd_pos;

	// Take the next operation whenever the result register is free or being drained.
	assign op_pop = op_valid && (!out_valid_q || result.ready);

	// Store path: rotate on a batch start over a full newest layer, then append if room.
	always_comb begin
		full      = newest_len_q == DEPTH_L;
		rotate    = (op.kind == plcb_pkg::OP_STORE) && op.batch && full;
		if (rotate) begin
			slot_n   = (newest_q == '0) ? LAST_SLOT : newest_q - 1'b1;
			len_base = '0;
		end else begin
			slot_n   = newest_q;
			len_base = newest_len_q;
		end
		do_write  = (op.kind == plcb_pkg::OP_STORE) && (len_base != DEPTH_L);
		len_store = do_write ? len_base + 1'b1 : len_base;
		wr_pos    = PW'(len_base);
	end

	// Read path: map the layer to its physical slot and check the entry against its length.
	always_comb begin
		slot_sum  = AW'(newest_q) + AW'(op.sel);
		slot_wrap = (slot_sum >= AW'(LAYER_COUNT)) ? slot_sum - AW'(LAYER_COUNT) : slot_sum;
		rd_slot   = slot_wrap[SW-1:0];
		rd_pos    = PW'(op.idx);
		hit       = (op.kind == plcb_pkg::OP_READ) && op.sel_ok &&
			(IW'(op.idx) < IW'(len_q[rd_slot]));
	end

	// Newest layer length after the operation and the count still wanted.
	always_comb begin
		case (op.kind)
			plcb_pkg::OP_STORE: len_after = len_store;
			plcb_pkg::OP_CLEAR: len_after = '0;
			default:            len_after = newest_len_q;
		endcase
		xmit = (len_after == DEPTH_L) ? DEPTH_L : DEPTH_L - len_after;
	end

	// Layer bookkeeping and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q     <= '0;
			newest_len_q <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < LAYER_COUNT; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			if (op_pop) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (op_pop) begin
				case (op.kind)
					plcb_pkg::OP_STORE: begin
						newest_q       <= slot_n;
						newest_len_q   <= len_store;
						len_q[slot_n]  <= len_store;
					end
					plcb_pkg::OP_CLEAR: begin
						newest_len_q <= '0;
						for (int i = 0; i < LAYER_COUNT; i++) begin
							len_q[i] <= '0;
						end
					end
					default: begin
						newest_len_q <= newest_len_q;
					end
				endcase
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (op_pop) begin
			read_valid_q <= hit;
			color_q      <= op.color;
			fill_q       <= plcb_pkg::LEN_W'(len_after);
			xmit_q       <= plcb_pkg::LEN_W'(xmit);
		end
	end

	// Sample store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (op_pop && do_write) begin
			mem[slot_n][wr_pos] <= op.sample;
		end
		if (op_pop && (op.kind == plcb_pkg::OP_READ)) begin
			rd_q <= mem[rd_slot][rd_pos];
		end
	end

	assign result.valid            = out_valid_q;
	assign result.data.read_value  = read_valid_q ? rd_q : '0;
	assign result.data.read_valid  = read_valid_q;
	assign result.data.layer_color = color_q;
	assign result.data.fill_length = fill_q;
	assign result.data.to_transmit = xmit_q;

	// The newest length shadow always matches its slot entry.
	a_newest_shadow: assert property (@(posedge clk) disable iff (!arst_n)
		newest_len_q == len_q[newest_q])
		else $error("newest layer length shadow out of step");

	// A layer never holds more than its depth.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		newest_len_q <= DEPTH_L)
		else $error("newest layer length beyond depth");

	// The newest slot stays within the layer ring.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(newest_q) < LAYER_COUNT)
		else $error("newest slot outside the layer ring");

	// A rotating store leaves exactly one sample in the new newest layer.
	a_rotate_one: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop && rotate |=> newest_len_q == LW'(1))
		else $error("rotation did not restart the newest layer");

endmodule

### design/persistence_layer_capture_buffer.sv
// Channel     | Dir | Handshake                  | Payload
// item        | in  | valid/ready                | cmd, sample_raw, batch_start, layer_sel, entry_index
// result      | out | valid/ready                | read_value, read_valid, layer_color, fill_length,
//             |     |                            | to_transmit
// APB config  | in  | psel/penable, pready high  | base_color at 0x0, sample_gain at 0x4
//
// One request is accepted per cycle while the queue has room. Each request passes through a front
// stage holding the gain and weight products, the queue and the back end result register. The
// sample store has one write and one registered read port, so the back end takes the next
// operation while its result register is being drained. Reset is asynchronous, active low, and
// clears every layer length at once; no clearing pass is needed. A stalled result holds the back
// end, while the front stage and the queue keep taking requests until the queue is full.
module persistence_layer_capture_buffer #(
	parameter int LAYER_COUNT = plcb_pkg::DEF_LAYER_COUNT,
	parameter int LAYER_DEPTH = plcb_pkg::DEF_LAYER_DEPTH,
	parameter int QUEUE_DEPTH = plcb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	plcb_item_if.sink                         item,
	plcb_result_if.source                     result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [plcb_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [plcb_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [plcb_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	logic [plcb_pkg::COLOR_W-1:0] base_color_q;
	logic [plcb_pkg::GAIN_W-1:0]  sample_gain_q;
	plcb_pkg::reg_idx_t           reg_idx;

	logic          front_valid;
	logic          queue_ready;
	plcb_pkg::op_t front_op;
	logic          queue_valid;
	logic          back_pop;
	plcb_pkg::op_t back_op;

	// Configuration registers, written in the access phase of a write request.
	assign pready  = 1'b1;
	assign reg_idx = plcb_pkg::reg_idx_t'(paddr[plcb_pkg::REG_ADDR_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_color_q  <= plcb_pkg::BASE_COLOR_RST;
			sample_gain_q <= plcb_pkg::SAMPLE_GAIN_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				plcb_pkg::REG_BASE_COLOR:  base_color_q  <= pwdata[plcb_pkg::COLOR_W-1:0];
				plcb_pkg::REG_SAMPLE_GAIN: sample_gain_q <= pwdata[plcb_pkg::GAIN_W-1:0];
				default:                   base_color_q  <= base_color_q;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (reg_idx)
			plcb_pkg::REG_SAMPLE_GAIN: prdata = plcb_pkg::APB_DATA_W'(sample_gain_q);
			default:                   prdata = plcb_pkg::APB_DATA_W'(base_color_q);
		endcase
	end

	plcb_front #(
		.LAYER_COUNT (LAYER_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.base_color  (base_color_q),
		.sample_gain (sample_gain_q),
		.op_valid    (front_valid),
		.op_ready    (queue_ready),
		.op          (front_op)
	);

	plcb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (queue_ready),
		.push_op    (front_op),
		.pop_valid  (queue_valid),
		.pop        (back_pop),
		.pop_op     (back_op)
	);

	plcb_back #(
		.LAYER_COUNT (LAYER_COUNT),
		.LAYER_DEPTH (LAYER_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (queue_valid),
		.op       (back_op),
		.op_pop   (back_pop),
		.result   (result)
	);

endmodule

### dv/tb_top.sv
// Testbench for the persistence layer capture buffer: directed, register sweep, random, stall
// and fill-and-rotate request streams, each result checked against an in-bench layer store.
// Depends on plcb_pkg, the plcb channel interfaces and persistence_layer_capture_buffer.
module tb_top;
	import plcb_pkg::*;

	localparam int LAYERS = DEF_LAYER_COUNT;
	localparam int DEPTH = DEF_LAYER_DEPTH;
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_CAP = 100;
	localparam int VAL_MAX = 2 ** (VAL_W - 1) - 1;
	localparam int VAL_MIN = -(2 ** (VAL_W - 1));
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	plcb_item_if item_if ();
	plcb_result_if res_if ();

	persistence_layer_capture_buffer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the layer store, the layer lengths and the registers.
	logic [VAL_W-1:0] shadow_store [LAYERS*DEPTH];
	int shadow_len [LAYERS];
	int shadow_newest = 0;
	logic [COLOR_W-1:0] shadow_color = BASE_COLOR_RST;
	logic [GAIN_W-1:0] shadow_gain = SAMPLE_GAIN_RST;

	result_t due_results [$];
	int mismatch_count = 0;
	bit src_idle = 1'b1;
	bit sink_idle = 1'b1;
	int sink_hold = 0;
	int sink_wait = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Run limit, far above the slowest legal run.
	initial begin
		#600000;
		$display("Some tests failed");
		$finish;
	end

	task automatic report_error(string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	// Sign-extend the 12-bit code, scale by the Q4.12 gain with round half up, saturate.
	function automatic logic [VAL_W-1:0] scale_adc_code(logic [RAW_W-1:0] raw);
		logic signed [CODE_W-1:0] code;
		int prod;
		int scaled;
		code = raw[CODE_W-1:0];
		prod = int'(code) * int'(shadow_gain) + ROUND_HALF;
		scaled = prod >>> GAIN_FRAC;
		if (scaled > VAL_MAX) begin
			scaled = VAL_MAX;
		end else if (scaled < VAL_MIN) begin
			scaled = VAL_MIN;
		end
		return VAL_W'(scaled);
	endfunction

	// Each RGB565 component is scaled by weight over the layer count, truncated.
	function automatic logic [COLOR_W-1:0] dim_rgb565(logic [COLOR_W-1:0] c, int w);
		int b;
		int g;
		int r;
		b = int'(c[COMP_B_W-1:0]) * w / LAYERS;
		g = int'(c[COMP_B_W +: COMP_G_W]) * w / LAYERS;
		r = int'(c[COMP_B_W+COMP_G_W +: COMP_R_W]) * w / LAYERS;
		return {COMP_R_W'(r), COMP_G_W'(g), COMP_B_W'(b)};
	endfunction

	// Apply one accepted request to the shadow state and return the result it must give.
	function automatic result_t capture_predict(item_t it);
		result_t res;
		int slot;
		int len;
		res = '0;
		if (it.cmd == CMD_STORE) begin
			if (it.batch_start && shadow_len[shadow_newest] >= DEPTH) begin
				shadow_newest = (shadow_newest + LAYERS - 1) % LAYERS;
				shadow_len[shadow_newest] = 0;
			end
			len = shadow_len[shadow_newest];
			if (len < DEPTH) begin
				shadow_store[shadow_newest * DEPTH + len] = scale_adc_code(it.sample_raw);
				shadow_len[shadow_newest] = len + 1;
			end
		end else if (it.cmd == CMD_READ) begin
			slot = (shadow_newest + int'(it.layer_sel)) % LAYERS;
			if (int'(it.entry_index) < shadow_len[slot]) begin
				res.read_value = shadow_store[slot * DEPTH + int'(it.entry_index)];
				res.read_valid = 1'b1;
			end
		end else if (it.cmd == CMD_CLEAR) begin
			foreach (shadow_len[i]) begin
				shadow_len[i] = 0;
			end
		end
		res.layer_color = dim_rgb565(shadow_color, LAYERS - int'(it.layer_sel));
		len = shadow_len[shadow_newest];
		res.fill_length = LEN_W'(len);
		res.to_transmit = LEN_W'(len >= DEPTH ? DEPTH : DEPTH - len);
		return res;
	endfunction

	function automatic item_t make_item(logic [CMD_W-1:0] cmd, logic [RAW_W-1:0] raw,
		logic batch, logic [SEL_W-1:0] sel, logic [IDX_W-1:0] idx);
		item_t it;
		it.cmd = cmd;
		it.sample_raw = raw;
		it.batch_start = batch;
		it.layer_sel = sel;
		it.entry_index = idx;
		return it;
	endfunction

	// Mixed request with the read index biased toward the filled part of the chosen layer.
	function automatic item_t random_request();
		item_t it;
		int pick;
		int len;
		it.sample_raw = RAW_W'($urandom);
		it.batch_start = ($urandom_range(0, 3) == 0);
		it.layer_sel = $urandom_range(0, 1) ? SEL_W'(0) : SEL_W'($urandom);
		it.entry_index = IDX_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			it.cmd = CMD_STORE;
		end else if (pick < 90) begin
			it.cmd = CMD_READ;
		end else if (pick < 93) begin
			it.cmd = CMD_CLEAR;
		end else begin
			it.cmd = CMD_UNUSED;
		end
		len = shadow_len[(shadow_newest + int'(it.layer_sel)) % LAYERS];
		if ($urandom_range(0, 1)) begin
			it.entry_index = IDX_W'($urandom_range(0, len < DEPTH ? len : DEPTH - 1));
		end
		return it;
	endfunction

	// Offer one request, after a random gap if the source idles, and record its result once it is taken.
	task automatic send_request(item_t it);
		int gap;
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.data <= it;
		do @(posedge clk); while (!item_if.ready);
		due_results.push_back(capture_predict(it));
		@(negedge clk);
	endtask

	// Stop offering and wait until every outstanding result has come back.
	task automatic drain_results();
		item_if.valid <= 1'b0;
		while (due_results.size() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(r) << REG_ADDR_LSB;
		pwdata <= APB_DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (r == REG_BASE_COLOR) begin
			shadow_color = v;
		end else begin
			shadow_gain = v;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_reg(reg_idx_t r);
		logic [15:0] want;
		want = (r == REG_BASE_COLOR) ? shadow_color : shadow_gain;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APB_ADDR_W'(r) << REG_ADDR_LSB;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== want) begin
			report_error($sformatf("register %s read %h expected %h", r.name(), prdata[15:0], want));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [COLOR_W-1:0] color, logic [GAIN_W-1:0] gain);
		write_reg(REG_BASE_COLOR, color);
		write_reg(REG_SAMPLE_GAIN, gain);
		check_reg(REG_BASE_COLOR);
		check_reg(REG_SAMPLE_GAIN);
	endtask

	// Result ready: a long hold when a test asks for one, else a random wait per result if the sink idles.
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			res_if.ready <= 1'b0;
			sink_hold--;
		end else if (sink_wait > 0) begin
			res_if.ready <= 1'b0;
			sink_wait--;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest outstanding prediction.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.data;
			sink_wait = sink_idle ? $urandom_range(0, 15) : 0;
			if (due_results.size() == 0) begin
				report_error($sformatf("result with nothing outstanding: %p", got));
			end else begin
				want = due_results.pop_front();
				if (got.read_value !== want.read_value) begin
					report_error($sformatf("read_value got %0d expected %0d",
						got.read_value, want.read_value));
				end
				if (got.read_valid !== want.read_valid) begin
					report_error($sformatf("read_valid got %b expected %b",
						got.read_valid, want.read_valid));
				end
				if (got.layer_color !== want.layer_color) begin
					report_error($sformatf("layer_color got %h expected %h",
						got.layer_color, want.layer_color));
				end
				if (got.fill_length !== want.fill_length) begin
					report_error($sformatf("fill_length got %0d expected %0d",
						got.fill_length, want.fill_length));
				end
				if (got.to_transmit !== want.to_transmit) begin
					report_error($sformatf("to_transmit got %0d expected %0d",
						got.to_transmit, want.to_transmit));
				end
			end
		end
	end

	// Reset register values, code extremes, every command and the corner cases of reads.
	task automatic test_directed();
		check_reg(REG_BASE_COLOR);
		check_reg(REG_SAMPLE_GAIN);
		send_request(make_item(CMD_READ, 16'h0000, 1'b0, 3'd0, 10'd0));
		// A batch start on an empty layer appends without rotating.
		send_request(make_item(CMD_STORE, 16'h07FF, 1'b1, 3'd0, 10'd0));
		send_request(make_item(CMD_STORE, 16'h0800, 1'b0, 3'd1, 10'd0));
		send_request(make_item(CMD_STORE, 16'hF800, 1'b0, 3'd2, 10'd1023));
		send_request(make_item(CMD_STORE, 16'hFFFF, 1'b0, 3'd7, 10'd1023));
		send_request(make_item(CMD_STORE, 16'h0000, 1'b0, 3'd0, 10'd0));
		send_request(make_item(CMD_STORE, 16'hF7FF, 1'b1, 3'd4, 10'd512));
		// The last read is at the layer length, one past the last entry.
		for (int k = 0; k <= 6; k++) begin
			send_request(make_item(CMD_READ, 16'hFFFF, 1'b1, 3'd0, IDX_W'(k)));
		end
		send_request(make_item(CMD_READ, 16'h0000, 1'b0, 3'd7, 10'd1023));
		send_request(make_item(CMD_READ, 16'h0000, 1'b0, 3'd3, 10'd0));
		send_request(make_item(CMD_UNUSED, 16'hFFFF, 1'b1, 3'd7, 10'd1023));
		send_request(make_item(CMD_UNUSED, 16'h0000, 1'b0, 3'd0, 10'd0));
		send_request(make_item(CMD_CLEAR, 16'hFFFF, 1'b1, 3'd5, 10'd1023));
		send_request(make_item(CMD_READ, 16'h0000, 1'b0, 3'd0, 10'd0));
		send_request(make_item(CMD_STORE, 16'h0123, 1'b1, 3'd0, 10'd0));
		send_request(make_item(CMD_READ, 16'h0000, 1'b0, 3'd0, 10'd0));
		drain_results();
	endtask

	// Gain and color extremes, rounding ties and the color weight of every layer.
	task automatic test_config_sweep();
		logic [GAIN_W-1:0] gains [6];
		logic [COLOR_W-1:0] colors [6];
		logic [CODE_W-1:0] codes [7];
		gains = '{16'd4096, 16'd0, 16'd1, 16'd2048, 16'hFFFF, GAIN_W'($urandom)};
		colors = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, COLOR_W'($urandom)};
		codes = '{12'h7FF, 12'h800, 12'h001, 12'hFFF, 12'h003, 12'hFFD, 12'h000};
		for (int s = 0; s < 6; s++) begin
			drain_results();
			set_config(colors[s], gains[s]);
			send_request(make_item(CMD_CLEAR, 16'h0000, 1'b0, 3'd0, 10'd0));
			foreach (codes[k]) begin
				send_request(make_item(CMD_STORE, {4'($urandom), codes[k]}, 1'b0,
					SEL_W'(k + 1), IDX_W'($urandom)));
			end
			for (int k = 0; k < 8; k++) begin
				send_request(make_item(CMD_READ, RAW_W'($urandom), 1'($urandom), 3'd0, IDX_W'(k)));
			end
		end
		drain_results();
	endtask

	// Random mix under several idling patterns.
	task automatic test_random_mix();
		set_config(COLOR_W'($urandom), GAIN_W'($urandom));
		for (int i = 0; i < 200; i++) begin
			src_idle = (i < 100) || (i >= 150);
			sink_idle = (i < 100);
			send_request(random_request());
		end
		drain_results();
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// Long result stall while requests keep coming, then requests to an idling sink, each run drained.
	task automatic test_backpressure();
		src_idle = 1'b0;
		sink_idle = 1'b0;
		sink_hold = 80;
		repeat (30) send_request(random_request());
		drain_results();
		sink_idle = 1'b1;
		repeat (30) send_request(random_request());
		drain_results();
		src_idle = 1'b1;
	endtask

	// Fill the newest layer, drop extras, rotate on a batch start and read across layers.
	task automatic test_fill_and_rotate();
		item_t it;
		int pick;
		int len;
		set_config(COLOR_W'($urandom), GAIN_W'($urandom));
		send_request(make_item(CMD_CLEAR, 16'h0000, 1'b0, 3'd0, 10'd0));
		src_idle = 1'b0;
		sink_idle = 1'b0;
		while (shadow_len[shadow_newest] < DEPTH) begin
			len = shadow_len[shadow_newest];
			if (len >= DEPTH / 2) begin
				src_idle = 1'b1;
				sink_idle = 1'b1;
			end
			if ($urandom_range(0, 99) < 6) begin
				it = make_item(CMD_READ, RAW_W'($urandom), 1'($urandom), 3'd0,
					IDX_W'($urandom_range(0, len)));
			end else begin
				it = make_item(CMD_STORE, RAW_W'($urandom), $urandom_range(0, 7) == 0,
					SEL_W'($urandom), IDX_W'($urandom));
			end
			send_request(it);
		end
		// A full layer drops plain stores but still serves its last entry.
		repeat (8) begin
			send_request(make_item(CMD_STORE, RAW_W'($urandom), 1'b0, SEL_W'($urandom),
				IDX_W'($urandom)));
		end
		send_request(make_item(CMD_READ, RAW_W'($urandom), 1'b0, 3'd0, IDX_W'(DEPTH - 1)));
		send_request(make_item(CMD_STORE, RAW_W'($urandom), 1'b1, 3'd0, 10'd0));
		repeat (100) begin
			pick = $urandom_range(0, 99);
			len = shadow_len[shadow_newest];
			if (pick < 45) begin
				it = make_item(CMD_STORE, RAW_W'($urandom), $urandom_range(0, 3) == 0,
					SEL_W'($urandom), IDX_W'($urandom));
			end else if (pick < 97) begin
				it = make_item(CMD_READ, RAW_W'($urandom), 1'($urandom),
					SEL_W'($urandom_range(0, 2)),
					$urandom_range(0, 1) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, len)));
			end else begin
				it = make_item(CMD_UNUSED, RAW_W'($urandom), 1'($urandom), SEL_W'($urandom),
					IDX_W'($urandom));
			end
			send_request(it);
		end
		send_request(make_item(CMD_CLEAR, RAW_W'($urandom), 1'b1, 3'd1, 10'd0));
		send_request(make_item(CMD_READ, RAW_W'($urandom), 1'b0, 3'd1, 10'd0));
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.data = '0;
		res_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_config_sweep();
		test_random_mix();
		test_backpressure();
		test_fill_and_rotate();
		drain_results();
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
